FILE: hdl/pkcs1_v15_pad_checker_core_defines.svh
// Assertion macros shared by the padding checker.
`ifndef PKCS1_V15_PAD_CHECKER_CORE_DEFINES_SVH
`define PKCS1_V15_PAD_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PKPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PKPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pkpc_pkg.sv
`timescale 1ns / 1ps

package pkpc_pkg;

  localparam int unsigned CNT_W = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SHA1   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SHA256 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHA384 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHA512 = 3'd4;

  localparam logic [7:0] HDR0_BYTE = 8'h00;
  localparam logic [7:0] HDR1_BYTE = 8'h01;
  localparam logic [7:0] PAD_BYTE  = 8'hFF;
  localparam logic [7:0] SEP_BYTE  = 8'h00;

  localparam int unsigned MIN_PAD = 8;
  localparam int unsigned PAD_W   = 4;

  localparam int unsigned PREFIX_DEPTH = 19;
  localparam int unsigned PIDX_W       = 5;

  localparam logic [7:0] DIGEST_INFO [4][PREFIX_DEPTH] = '{
    '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
      8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
    '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
    '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
  };

  typedef struct packed {
    logic [CNT_W-1:0] msg_length;
    logic             check_status;
    logic             frame_done;
    logic             msg_valid;
    logic [7:0]       msg_byte;
  } result_t;

  function automatic logic is_digest_mode(input logic [MODE_W-1:0] mode);
    return (mode >= MODE_SHA1) && (mode <= MODE_SHA512);
  endfunction

  function automatic logic [PIDX_W-1:0] prefix_len(input logic [MODE_W-1:0] mode);
    logic [PIDX_W-1:0] len;
    case (mode)
      MODE_SHA1:   len = 5'd15;
      MODE_SHA256: len = 5'd19;
      MODE_SHA384: len = 5'd19;
      MODE_SHA512: len = 5'd19;
      default:     len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [CNT_W-1:0] digest_len(input logic [MODE_W-1:0] mode);
    logic [CNT_W-1:0] len;
    case (mode)
      MODE_SHA1:   len = 10'd20;
      MODE_SHA256: len = 10'd32;
      MODE_SHA384: len = 10'd48;
      MODE_SHA512: len = 10'd64;
      default:     len = 10'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [MODE_W-1:0] mode,
                                             input logic [PIDX_W-1:0] idx);
    logic [1:0]   row;
    logic [MODE_W-1:0] m1;
    logic [7:0]   val;
    m1  = mode - MODE_SHA1;
    row = m1[1:0];
    if (idx < PIDX_W'(PREFIX_DEPTH)) begin
      val = DIGEST_INFO[row][idx];
    end else begin
      val = 8'h00;
    end
    return val;
  endfunction

endpackage

FILE: hdl/pkpc_frame_ctl.sv
`timescale 1ns / 1ps

module pkpc_frame_ctl #(
  parameter int unsigned MAX_EM_BYTES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [7:0]                  em_byte,
  input  logic                        em_last,
  input  logic [pkpc_pkg::MODE_W-1:0] mode,
  output logic                        res_emit,
  output pkpc_pkg::result_t           res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_PAD,
    PH_PREFIX,
    PH_BODY,
    PH_DRAIN
  } phase_t;

  localparam int unsigned POS_CMP_W = pkpc_pkg::CNT_W + 1;

  phase_t                        phase_r, phase_nxt;
  logic [pkpc_pkg::CNT_W-1:0]    pos_r, pos_nxt;
  logic [pkpc_pkg::PAD_W-1:0]    pad_r, pad_nxt;
  logic [pkpc_pkg::PIDX_W-1:0]   pidx_r, pidx_nxt;
  logic [pkpc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          fail_r, fail_nxt;
  logic                          body;
  logic [pkpc_pkg::PIDX_W-1:0]   tl;
  logic [pkpc_pkg::PIDX_W-1:0]   pidx_inc;

  always_comb begin
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    pidx_nxt  = pidx_r;
    fail_nxt  = fail_r;
    body      = 1'b0;
    tl        = pkpc_pkg::prefix_len(mode);
    pidx_inc  = pidx_r + pkpc_pkg::PIDX_W'(1);

    // A byte beyond the frame limit spoils the frame.
    if ({1'b0, pos_r} >= POS_CMP_W'(MAX_EM_BYTES)) begin
      fail_nxt = 1'b1;
    end

    case (phase_r)
      PH_HDR0: begin
        if (em_byte != pkpc_pkg::HDR0_BYTE) begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_DRAIN;
        end else begin
          phase_nxt = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (em_byte != pkpc_pkg::HDR1_BYTE) begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_DRAIN;
        end else begin
          phase_nxt = PH_PAD;
        end
      end
      PH_PAD: begin
        if (em_byte == pkpc_pkg::PAD_BYTE) begin
          // Only "at least eight" matters, so the run count stops at eight.
          if (pad_r < pkpc_pkg::PAD_W'(pkpc_pkg::MIN_PAD)) begin
            pad_nxt = pad_r + pkpc_pkg::PAD_W'(1);
          end
        end else if (em_byte == pkpc_pkg::SEP_BYTE) begin
          if (pad_r < pkpc_pkg::PAD_W'(pkpc_pkg::MIN_PAD)) begin
            fail_nxt = 1'b1;
          end
          pidx_nxt  = '0;
          phase_nxt = pkpc_pkg::is_digest_mode(mode) ? PH_PREFIX : PH_BODY;
        end else begin
          fail_nxt  = 1'b1;
          phase_nxt = PH_DRAIN;
        end
      end
      PH_PREFIX: begin
        if ((pidx_r < tl) && (tl != '0)) begin
          if (em_byte != pkpc_pkg::prefix_byte(mode, pidx_r)) begin
            fail_nxt = 1'b1;
          end
          pidx_nxt = pidx_inc;
          if (pidx_inc >= tl) begin
            phase_nxt = PH_BODY;
          end
        end else begin
          // The mode moved under us and the prefix is already covered.
          phase_nxt = PH_BODY;
          body      = 1'b1;
        end
      end
      PH_BODY: begin
        body = 1'b1;
      end
      default: begin
        phase_nxt = PH_DRAIN;
      end
    endcase

    cnt_nxt = (body && (cnt_r != pkpc_pkg::CNT_MAX)) ? cnt_r + pkpc_pkg::CNT_W'(1) : cnt_r;
    pos_nxt = (pos_r != pkpc_pkg::CNT_MAX) ? pos_r + pkpc_pkg::CNT_W'(1) : pos_r;

    res              = '0;
    res.msg_byte     = body ? em_byte : 8'h00;
    res.msg_valid    = body;
    res_emit         = body || em_last;

    if (em_last) begin
      if (phase_nxt == PH_BODY) begin
        res.msg_length = cnt_nxt;
        if (mode > pkpc_pkg::MODE_SHA512) begin
          fail_nxt = 1'b1;
        end
        if (pkpc_pkg::is_digest_mode(mode) && (cnt_nxt != pkpc_pkg::digest_len(mode))) begin
          fail_nxt = 1'b1;
        end
      end else begin
        res.msg_length = '0;
        fail_nxt       = 1'b1;
      end
      res.frame_done   = 1'b1;
      res.check_status = fail_nxt;
      phase_nxt        = PH_HDR0;
      pos_nxt          = '0;
      pad_nxt          = '0;
      pidx_nxt         = '0;
      cnt_nxt          = '0;
      fail_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      pos_r   <= '0;
      pad_r   <= '0;
      pidx_r  <= '0;
      cnt_r   <= '0;
      fail_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      pad_r   <= pad_nxt;
      pidx_r  <= pidx_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

FILE: hdl/pkcs1_v15_pad_checker_core.sv
`timescale 1ns / 1ps

// PKCS #1 v1.5 padding checker. Feed the encoded message one byte per word,
// most significant byte first, with in_tlast on its final byte. The block
// checks the 00 01 header, at least eight FF padding bytes and the 00
// separator, and in digest modes the DigestInfo prefix and digest length.
// Every message or digest byte comes out as a word with out_tuser set; the
// word for the final input byte has out_tlast set and carries the pass/fail
// status and the message length (zero when the header is bad, the separator
// is missing or the prefix is cut short). One byte is taken every clock
// cycle unless the output is back-pressured; each byte passes through an
// input register and a result register before its word is presented. Bytes
// that produce no result (header, padding, prefix) still pass through the
// input register. The user must write padding_mode through cfg_wen/cfg_wdata
// only while no frame is in flight; the block itself does not enforce this.
module pkcs1_v15_pad_checker_core #(
  parameter int unsigned MAX_EM_BYTES = 512
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // em_byte[7:0]
  input  logic                        in_tlast,   // em_last
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // msg_byte[7:0], check_status[8],
                                                  // msg_length[18:9], zero[23:19]
  output logic                        out_tuser,  // msg_valid
  output logic                        out_tlast,  // frame_done
  input  logic                        cfg_wen,
  input  logic [pkpc_pkg::MODE_W-1:0] cfg_wdata   // padding_mode
);

  logic [pkpc_pkg::MODE_W-1:0] mode_r;
  logic                        s1_valid_r;
  logic [7:0]                  s1_byte_r;
  logic                        s1_last_r;
  logic                        out_valid_r;
  pkpc_pkg::result_t           out_res_r;
  logic                        out_load_ok;
  logic                        s1_fire;
  logic                        in_fire;
  logic                        res_emit;
  pkpc_pkg::result_t           res;

  assign out_load_ok = !out_valid_r || out_tready;
  assign s1_fire     = s1_valid_r && out_load_ok;
  assign in_tready   = !s1_valid_r || out_load_ok;
  assign in_fire     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pkpc_pkg::MODE_PLAIN;
    end else if (cfg_wen) begin
      mode_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  pkpc_frame_ctl #(
    .MAX_EM_BYTES (MAX_EM_BYTES)
  ) u_frame_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_fire),
    .em_byte  (s1_byte_r),
    .em_last  (s1_last_r),
    .mode     (mode_r),
    .res_emit (res_emit),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && res_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && res_emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.msg_valid;
  assign out_tlast  = out_res_r.frame_done;
  assign out_tdata  = {5'd0, out_res_r.msg_length, out_res_r.check_status,
                       out_res_r.msg_byte};

`include "pkcs1_v15_pad_checker_core_defines.svh"

  // A word with no message byte can only be the end-of-frame report.
  `PKPC_ASSERT_NOW(a_empty_word_is_done, out_tvalid && !out_tuser, out_tlast, "empty word without frame end")

  // Status and length are only reported on the end-of-frame word.
  `PKPC_ASSERT_NOW(a_status_only_at_done, out_tvalid && !out_tlast, out_tdata[18:8] == 11'd0, "status outside frame end")

  // A held input byte stays in the input register until it can move on.
  `PKPC_ASSERT_NEXT(a_s1_holds, s1_valid_r && !out_load_ok, s1_valid_r && $stable(s1_byte_r), "input stage lost a byte")

endmodule

FILE: verif/pkcs1_v15_pad_checker_core_tb.sv
`timescale 1ns / 1ps

module pkcs1_v15_pad_checker_core_tb;

  localparam int unsigned EM_LIMIT     = 512;
  localparam int unsigned SAT_LIMIT    = 1023;
  localparam int unsigned ITEM_TARGET  = 1100;
  localparam int unsigned LONG_AFTER   = 40;
  localparam int unsigned CFG_SETTLE   = 4;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [pkpc_pkg::MODE_W-1:0] MODE_UNDEF_MAX = 3'd7;
  localparam logic [pkpc_pkg::MODE_W-1:0] MODE_UNDEF_MIN = 3'd5;

  // DER DigestInfo prefixes, one row per hash in mode order.
  localparam logic [7:0] HASH_PREFIX [4][19] = '{
    '{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2b, 8'h0e, 8'h03, 8'h02,
      8'h1a, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
    '{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
    '{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
      8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40}
  };

  typedef enum logic [2:0] {
    ST_HDR0, ST_HDR1, ST_PAD, ST_PREFIX, ST_BODY, ST_DRAIN
  } em_phase_t;

  typedef enum int {
    FR_GOOD, FR_BAD_HDR, FR_NO_SEP, FR_END_PAD, FR_SHORT_PAD,
    FR_PFX_BAD, FR_PFX_CUT, FR_BAD_LEN, FR_NOISE
  } frame_kind_t;

  typedef struct packed {
    logic                        wr;
    logic [pkpc_pkg::MODE_W-1:0] mode;
    logic [7:0]                  b;
    logic                        last;
    logic                        typed;
  } dir_row_t;

  // A frame that fails before any message byte ends with this word.
  localparam pkpc_pkg::result_t FAIL_EMPTY = '{msg_length: '0, check_status: 1'b1,
                                               frame_done: 1'b1, msg_valid: 1'b0,
                                               msg_byte: 8'h00};

  localparam int unsigned DIR_N = 23;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::PAD_BYTE, 1'b1, 1'b1},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, 8'h00, 1'b1, 1'b1},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR1_BYTE, 1'b1, 1'b1},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR1_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::PAD_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, 8'h7E, 1'b1, 1'b1},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::HDR1_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::PAD_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, pkpc_pkg::SEP_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_PLAIN, 8'h00, 1'b1, 1'b0},
    '{1'b1, pkpc_pkg::MODE_SHA1, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_SHA1, pkpc_pkg::HDR1_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_SHA1, pkpc_pkg::PAD_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_SHA1, pkpc_pkg::SEP_BYTE, 1'b0, 1'b0},
    '{1'b0, pkpc_pkg::MODE_SHA1, 8'h30, 1'b1, 1'b1},
    '{1'b1, MODE_UNDEF_MAX, pkpc_pkg::HDR0_BYTE, 1'b0, 1'b0},
    '{1'b0, MODE_UNDEF_MAX, pkpc_pkg::HDR1_BYTE, 1'b0, 1'b0},
    '{1'b0, MODE_UNDEF_MAX, pkpc_pkg::SEP_BYTE, 1'b0, 1'b0},
    '{1'b0, MODE_UNDEF_MAX, 8'h55, 1'b1, 1'b0}
  };

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic                        in_tready;
  logic [7:0]                  in_tdata   = 8'h00;
  logic                        in_tlast   = 1'b0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [23:0]                 out_tdata;
  logic                        out_tuser;
  logic                        out_tlast;
  logic                        cfg_wen    = 1'b0;
  logic [pkpc_pkg::MODE_W-1:0] cfg_wdata  = '0;

  // Decoder copy of the block state.
  logic [pkpc_pkg::MODE_W-1:0] cur_mode = pkpc_pkg::MODE_PLAIN;
  em_phase_t                   ph       = ST_HDR0;
  int unsigned                 em_pos   = 0;
  int unsigned                 ff_run   = 0;
  int unsigned                 pfx_idx  = 0;
  int unsigned                 body_cnt = 0;
  logic                        bad      = 1'b0;

  pkpc_pkg::result_t out_words_q [$];
  int unsigned errors      = 0;
  int unsigned sent        = 0;
  int unsigned cycle_count = 0;
  int          tx_calm     = 0;
  int          rx_calm     = 0;
  int          rx_gap      = 0;
  int          hold_left   = 0;
  bit          hold_req    = 1'b0;

  always #5 clk = ~clk;

  pkcs1_v15_pad_checker_core #(
    .MAX_EM_BYTES(EM_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned sat_up(input int unsigned v);
    return (v < SAT_LIMIT) ? v + 1 : SAT_LIMIT;
  endfunction

  function automatic logic is_hash_mode(input logic [pkpc_pkg::MODE_W-1:0] m);
    return (m >= pkpc_pkg::MODE_SHA1) && (m <= pkpc_pkg::MODE_SHA512);
  endfunction

  function automatic int unsigned pfx_len(input logic [pkpc_pkg::MODE_W-1:0] m);
    if (m == pkpc_pkg::MODE_SHA1) return 15;
    if (is_hash_mode(m)) return 19;
    return 0;
  endfunction

  function automatic int unsigned hash_len(input logic [pkpc_pkg::MODE_W-1:0] m);
    case (m)
      pkpc_pkg::MODE_SHA1:   return 20;
      pkpc_pkg::MODE_SHA256: return 32;
      pkpc_pkg::MODE_SHA384: return 48;
      pkpc_pkg::MODE_SHA512: return 64;
      default:               return 0;
    endcase
  endfunction

  function automatic logic [1:0] pfx_row(input logic [pkpc_pkg::MODE_W-1:0] m);
    logic [pkpc_pkg::MODE_W-1:0] d;
    d = m - pkpc_pkg::MODE_SHA1;
    return d[1:0];
  endfunction

  // Advances the decoder by one encoded byte and gives the word it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      output pkpc_pkg::result_t r, output logic emit);
    logic        body;
    int unsigned tl;
    body = 1'b0;
    emit = 1'b0;
    r    = '0;
    if (em_pos >= EM_LIMIT) bad = 1'b1;
    case (ph)
      ST_HDR0: begin
        if (b != pkpc_pkg::HDR0_BYTE) begin
          bad = 1'b1;
          ph  = ST_DRAIN;
        end else begin
          ph = ST_HDR1;
        end
      end
      ST_HDR1: begin
        if (b != pkpc_pkg::HDR1_BYTE) begin
          bad = 1'b1;
          ph  = ST_DRAIN;
        end else begin
          ph = ST_PAD;
        end
      end
      ST_PAD: begin
        if (b == pkpc_pkg::PAD_BYTE) begin
          ff_run = sat_up(ff_run);
        end else if (b == pkpc_pkg::SEP_BYTE) begin
          if (ff_run < pkpc_pkg::MIN_PAD) bad = 1'b1;
          pfx_idx = 0;
          ph = is_hash_mode(cur_mode) ? ST_PREFIX : ST_BODY;
        end else begin
          bad = 1'b1;
          ph  = ST_DRAIN;
        end
      end
      ST_PREFIX: begin
        tl = pfx_len(cur_mode);
        if (pfx_idx < tl) begin
          if (b != HASH_PREFIX[pfx_row(cur_mode)][pfx_idx % 19]) bad = 1'b1;
          pfx_idx++;
          if (pfx_idx >= tl) ph = ST_BODY;
        end else begin
          ph   = ST_BODY;
          body = 1'b1;
        end
      end
      ST_BODY: body = 1'b1;
      default: ph = ST_DRAIN;
    endcase
    if (body) begin
      emit        = 1'b1;
      body_cnt    = sat_up(body_cnt);
      r.msg_byte  = b;
      r.msg_valid = 1'b1;
    end
    em_pos = sat_up(em_pos);
    if (last) begin
      emit = 1'b1;
      if (ph == ST_BODY) begin
        r.msg_length = pkpc_pkg::CNT_W'(body_cnt);
        if (cur_mode > pkpc_pkg::MODE_SHA512) bad = 1'b1;
        if (is_hash_mode(cur_mode) && body_cnt != hash_len(cur_mode)) bad = 1'b1;
      end else begin
        bad = 1'b1;
      end
      r.frame_done   = 1'b1;
      r.check_status = bad;
      ph       = ST_HDR0;
      em_pos   = 0;
      ff_run   = 0;
      pfx_idx  = 0;
      body_cnt = 0;
      bad      = 1'b0;
    end
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last,
                           input logic typed, input pkpc_pkg::result_t typed_word);
    int                gap;
    pkpc_pkg::result_t r;
    logic              emit;
    gap = pick_gap(tx_calm);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, last, r, emit);
    if (typed) out_words_q.push_back(typed_word);
    else if (emit) out_words_q.push_back(r);
    sent++;
  endtask

  // The mode is changed only between frames, once every word has come out.
  task automatic write_mode(input logic [pkpc_pkg::MODE_W-1:0] m);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (out_words_q.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cur_mode = m;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic send_frame(input logic overlong);
    logic [7:0]  fr [$];
    frame_kind_t kind;
    int          npad;
    int          plen;
    int          dlen;
    int          cut;
    int          i;
    logic [7:0]  v;
    if (overlong) begin
      write_mode(pkpc_pkg::MODE_PLAIN);
    end else if ($urandom_range(0, 3) == 0) begin
      if ($urandom_range(0, 99) < 85) begin
        write_mode(pkpc_pkg::MODE_W'($urandom_range(0, 4)));
      end else begin
        write_mode(pkpc_pkg::MODE_W'($urandom_range(MODE_UNDEF_MIN, MODE_UNDEF_MAX)));
      end
    end
    kind = FR_GOOD;
    if (!overlong && $urandom_range(0, 99) >= 62) kind = frame_kind_t'($urandom_range(1, 8));
    npad = 8 + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4));
    if (kind == FR_SHORT_PAD) npad = $urandom_range(0, 7);
    fr = '{pkpc_pkg::HDR0_BYTE, pkpc_pkg::HDR1_BYTE};
    repeat (npad) fr.push_back(pkpc_pkg::PAD_BYTE);
    fr.push_back(pkpc_pkg::SEP_BYTE);
    plen = pfx_len(cur_mode);
    for (i = 0; i < plen; i++) fr.push_back(HASH_PREFIX[pfx_row(cur_mode)][i]);
    dlen = is_hash_mode(cur_mode) ? hash_len(cur_mode) : $urandom_range(0, 24);
    if (overlong) dlen = $urandom_range(510, 1040);
    if (kind == FR_BAD_LEN) begin
      if (dlen > 3 && $urandom_range(0, 1) == 0) dlen = dlen - $urandom_range(1, 3);
      else dlen = dlen + $urandom_range(1, 3);
    end
    repeat (dlen) fr.push_back(8'($urandom_range(0, 255)));
    case (kind)
      FR_BAD_HDR: begin
        if ($urandom_range(0, 1) == 0) begin
          fr[0] = 8'($urandom_range(1, 255));
        end else begin
          v = 8'($urandom_range(0, 255));
          fr[1] = (v == pkpc_pkg::HDR1_BYTE) ? 8'h81 : v;
        end
      end
      FR_NO_SEP:  fr[2 + npad] = 8'($urandom_range(1, 254));
      FR_END_PAD: begin
        cut = $urandom_range(1, 2 + npad);
        fr  = fr[0:cut-1];
      end
      FR_PFX_BAD: begin
        if (plen > 0) begin
          i = 3 + npad + $urandom_range(0, plen - 1);
          fr[i] = fr[i] ^ 8'($urandom_range(1, 255));
        end
      end
      FR_PFX_CUT: begin
        if (plen > 0) begin
          cut = 3 + npad + $urandom_range(1, plen - 1);
          fr  = fr[0:cut-1];
        end
      end
      FR_NOISE: begin
        fr = {};
        repeat ($urandom_range(1, 6)) fr.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    for (i = 0; i < fr.size(); i++) send_byte(fr[i], i == fr.size() - 1, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pkpc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_words_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h/%b/%b", $time,
                 out_tdata, out_tuser, out_tlast);
        errors++;
      end else begin
        want = out_words_q.pop_front();
        check_field("msg_byte", want.msg_byte, out_tdata[7:0]);
        check_field("msg_valid", want.msg_valid, out_tuser);
        check_field("frame_done", want.frame_done, out_tlast);
        check_field("check_status", want.check_status, out_tdata[8]);
        check_field("msg_length", want.msg_length, out_tdata[18:9]);
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = $urandom_range(300, 500);
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_tready <= 1'b0;
        rx_gap--;
      end else begin
        out_tready <= 1'b1;
        rx_gap = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, out_words_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    int unsigned rand_start;
    bit          long_done;
    long_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].wr) write_mode(DIR_ROWS[k].mode);
      send_byte(DIR_ROWS[k].b, DIR_ROWS[k].last, DIR_ROWS[k].typed, FAIL_EMPTY);
    end
    // Start the long hold-off from an empty block so the sender keeps offering into it.
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (out_words_q.size() != 0) @(posedge clk);
    hold_req   = 1'b1;
    rand_start = sent;
    while (sent - rand_start < ITEM_TARGET) begin
      if (!long_done && sent - rand_start > LONG_AFTER) begin
        send_frame(1'b1);
        long_done = 1'b1;
      end else begin
        send_frame(1'b0);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (out_words_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
